// ----- hw/rtl/sofp_pkg.sv -----
// sofp_pkg: shared types and codes for the start-of-frame / length / xor frame parser
// item and result structs, event codes, input kinds and configuration register indexes
// no dependencies
package sofp_pkg;

    localparam logic [7:0] SofChecked   = 8'hFE;
    localparam logic [7:0] SofUnchecked = 8'hFF;

    localparam logic KindByte = 1'b0;
    localparam logic KindTick = 1'b1;

    localparam logic [2:0] EvCmd0    = 3'd0;
    localparam logic [2:0] EvCmd1    = 3'd1;
    localparam logic [2:0] EvPayload = 3'd2;
    localparam logic [2:0] EvGood    = 3'd3;
    localparam logic [2:0] EvBad     = 3'd4;
    localparam logic [2:0] EvAbort   = 3'd5;

    localparam int CfgIndexWidth = 1;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CfgIdleTicks     = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CfgMaxDataLength = 1'd1;

    localparam logic [7:0]  IdleTicksReset     = 8'd3;
    localparam logic [15:0] MaxDataLengthReset = 16'd1018;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [7:0]  out_byte;
        logic [15:0] frame_length;
        logic        frame_end;
    } result_t;

endpackage

// ----- hw/rtl/sof_length_xor_frame_parser_unit.sv -----
// sof_length_xor_frame_parser_unit: frame parser, input register, one step of parse logic,
// result register. depends on sofp_pkg for item/result types and codes
// an accepted item waits in the input register; its result, if any, enters the result
// register when the input register advances. throughput: one item per cycle; the input
// register advances whenever its item gives no result or the result register is empty
// or being drained, so only a stalled result holds back the input
// reset: asynchronous active-low; parser returns to hunting, idle_ticks = 3,
// max_data_length = 1018, both registers empty
module sof_length_xor_frame_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  sofp_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output sofp_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sofp_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [sofp_pkg::CfgDataWidth-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_CMD0,
        PH_CMD1,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DROP
    } phase_t;

    // configuration
    logic [7:0]  idle_ticks_reg;
    logic [15:0] max_data_length_reg;

    // input register
    logic            stage_valid_reg;
    logic            stage_valid_next;
    sofp_pkg::item_t stage_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic        checked_frame_reg, checked_frame_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  idle_count_reg, idle_count_next;

    // result register
    logic              result_valid_reg, result_valid_next;
    sofp_pkg::result_t result_reg, result_next;

    logic        res_fire;
    logic [2:0]  res_code;
    logic [7:0]  res_byte;
    logic        res_end;
    logic        stage_advance;
    logic        item_accept;
    logic [15:0] bytes_left_dec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg      <= sofp_pkg::IdleTicksReset;
            max_data_length_reg <= sofp_pkg::MaxDataLengthReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sofp_pkg::CfgIdleTicks:     idle_ticks_reg      <= cfg_data[7:0];
                sofp_pkg::CfgMaxDataLength: max_data_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign bytes_left_dec = bytes_left_reg - 16'd1;

    // one parse step on the item held in the input register
    always_comb
    begin
        phase_next           = phase_reg;
        checked_frame_next   = checked_frame_reg;
        declared_length_next = declared_length_reg;
        bytes_left_next      = bytes_left_reg;
        running_xor_next     = running_xor_reg;
        idle_count_next      = idle_count_reg;
        res_fire             = 1'b0;
        res_code             = sofp_pkg::EvGood;
        res_byte             = 8'd0;
        res_end              = 1'b0;

        if (stage_reg.kind == sofp_pkg::KindTick)
        begin
            if (idle_count_reg != 8'd0)
            begin
                idle_count_next = idle_count_reg - 8'd1;
            end
            else if (phase_reg == PH_DROP)
            begin
                phase_next = PH_HUNT;
            end
            else if (phase_reg != PH_HUNT)
            begin
                // timeout with a frame open
                phase_next = PH_HUNT;
                res_fire   = 1'b1;
                res_code   = sofp_pkg::EvAbort;
                res_end    = 1'b1;
            end
        end
        else
        begin
            idle_count_next = idle_ticks_reg;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (stage_reg.rx_byte == sofp_pkg::SofChecked ||
                        stage_reg.rx_byte == sofp_pkg::SofUnchecked)
                    begin
                        checked_frame_next   = (stage_reg.rx_byte == sofp_pkg::SofChecked);
                        declared_length_next = 16'd0;
                        bytes_left_next      = 16'd0;
                        running_xor_next     = 8'd0;
                        phase_next           = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    declared_length_next = {stage_reg.rx_byte, 8'd0};
                    running_xor_next     = running_xor_reg ^ stage_reg.rx_byte;
                    phase_next           = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    declared_length_next = {declared_length_reg[15:8], stage_reg.rx_byte};
                    running_xor_next     = running_xor_reg ^ stage_reg.rx_byte;
                    if ({declared_length_reg[15:8], stage_reg.rx_byte} > max_data_length_reg)
                    begin
                        phase_next = PH_DROP;
                        res_fire   = 1'b1;
                        res_code   = sofp_pkg::EvAbort;
                        res_end    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CMD0;
                    end
                end
                PH_CMD0:
                begin
                    running_xor_next = running_xor_reg ^ stage_reg.rx_byte;
                    phase_next       = PH_CMD1;
                    res_fire         = 1'b1;
                    res_code         = sofp_pkg::EvCmd0;
                    res_byte         = stage_reg.rx_byte;
                end
                PH_CMD1:
                begin
                    running_xor_next = running_xor_reg ^ stage_reg.rx_byte;
                    bytes_left_next  = declared_length_reg;
                    phase_next       = (declared_length_reg != 16'd0) ? PH_PAYLOAD : PH_CHECK;
                    res_fire         = 1'b1;
                    res_code         = sofp_pkg::EvCmd1;
                    res_byte         = stage_reg.rx_byte;
                end
                PH_PAYLOAD:
                begin
                    running_xor_next = running_xor_reg ^ stage_reg.rx_byte;
                    bytes_left_next  = bytes_left_dec;
                    if (bytes_left_dec == 16'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    res_fire = 1'b1;
                    res_code = sofp_pkg::EvPayload;
                    res_byte = stage_reg.rx_byte;
                end
                PH_CHECK:
                begin
                    res_fire = 1'b1;
                    res_end  = 1'b1;
                    if (checked_frame_reg && stage_reg.rx_byte != running_xor_reg)
                    begin
                        phase_next = PH_DROP;
                        res_code   = sofp_pkg::EvBad;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        res_code   = sofp_pkg::EvGood;
                    end
                end
                PH_DROP: ;
                default: ;
            endcase
        end
    end

    // the input register moves on unless it has a result and the result register is blocked
    assign stage_advance = stage_valid_reg &&
                           (!res_fire || !result_valid_reg || !result_stall);
    assign item_stall    = stage_valid_reg && !stage_advance;
    assign item_accept   = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_advance)
        begin
            stage_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (stage_advance && res_fire)
        begin
            result_valid_next        = 1'b1;
            result_next.event_code   = res_code;
            result_next.out_byte     = res_byte;
            result_next.frame_length = declared_length_next;
            result_next.frame_end    = res_end;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg     <= 1'b0;
            stage_reg           <= '0;
            result_valid_reg    <= 1'b0;
            result_reg          <= '0;
            phase_reg           <= PH_HUNT;
            checked_frame_reg   <= 1'b0;
            declared_length_reg <= 16'd0;
            bytes_left_reg      <= 16'd0;
            running_xor_reg     <= 8'd0;
            idle_count_reg      <= 8'd0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            if (item_accept)
            begin
                stage_reg <= item;
            end
            if (stage_advance)
            begin
                phase_reg           <= phase_next;
                checked_frame_reg   <= checked_frame_next;
                declared_length_reg <= declared_length_next;
                bytes_left_reg      <= bytes_left_next;
                running_xor_reg     <= running_xor_next;
                idle_count_reg      <= idle_count_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/tb_sof_length_xor_frame_parser_unit.sv -----
// tb_sof_length_xor_frame_parser_unit: self-checking bench for the start-of-frame parser
// random and directed byte/tick streams, scoreboard fed by a built-in frame parser model
// depends on sofp_pkg and sof_length_xor_frame_parser_unit
module tb_sof_length_xor_frame_parser_unit;

    typedef enum logic [2:0] {
        PhHunt,
        PhLenHi,
        PhLenLo,
        PhCmd0,
        PhCmd1,
        PhPayload,
        PhCheck,
        PhDrop
    } parse_phase_t;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               item_valid   = 1'b0;
    logic                               item_stall;
    sofp_pkg::item_t                    item         = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    sofp_pkg::result_t                  result;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [sofp_pkg::CfgIndexWidth-1:0] cfg_index    = '0;
    logic [sofp_pkg::CfgDataWidth-1:0]  cfg_data     = '0;

    // parser model state and its copy of the registers
    parse_phase_t ph           = PhHunt;
    logic         is_checked   = 1'b0;
    logic [15:0]  len_decl     = '0;
    logic [15:0]  payload_left = '0;
    logic [7:0]   xor_acc      = '0;
    logic [7:0]   idle_left    = '0;
    logic [7:0]   idle_ticks_cfg = sofp_pkg::IdleTicksReset;
    logic [15:0]  max_len_cfg    = sofp_pkg::MaxDataLengthReset;

    sofp_pkg::item_t   pending_items [$];
    sofp_pkg::result_t expected_events [$];
    sofp_pkg::result_t predicted_event;
    sofp_pkg::result_t wanted_event;

    bit item_done   = 1'b0;
    bit sender_hold = 1'b0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int event_tally [6] = '{default: 0};

    sof_length_xor_frame_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic sofp_pkg::result_t make_event(input logic [2:0] code,
                                                     input logic [7:0] b,
                                                     input logic fin);
        sofp_pkg::result_t r;
        r.event_code   = code;
        r.out_byte     = b;
        r.frame_length = len_decl;
        r.frame_end    = fin;
        return r;
    endfunction

    function automatic bit parse_step(input sofp_pkg::item_t it,
                                      output sofp_pkg::result_t ev);
        logic [7:0] b;
        b  = it.rx_byte;
        ev = '0;
        if (it.kind == sofp_pkg::KindTick)
        begin
            if (idle_left != 8'd0)
            begin
                idle_left = idle_left - 8'd1;
                return 1'b0;
            end
            if (ph == PhHunt)
                return 1'b0;
            if (ph == PhDrop)
            begin
                ph = PhHunt;
                return 1'b0;
            end
            ph = PhHunt;
            ev = make_event(sofp_pkg::EvAbort, 8'd0, 1'b1);
            return 1'b1;
        end
        idle_left = idle_ticks_cfg;
        case (ph)
            PhHunt:
            begin
                if (b == sofp_pkg::SofChecked || b == sofp_pkg::SofUnchecked)
                begin
                    is_checked   = (b == sofp_pkg::SofChecked);
                    len_decl     = '0;
                    payload_left = '0;
                    xor_acc      = '0;
                    ph           = PhLenHi;
                end
                return 1'b0;
            end
            PhLenHi:
            begin
                len_decl = {b, 8'd0};
                xor_acc ^= b;
                ph       = PhLenLo;
                return 1'b0;
            end
            PhLenLo:
            begin
                len_decl = len_decl | {8'd0, b};
                xor_acc ^= b;
                if (len_decl > max_len_cfg)
                begin
                    ph = PhDrop;
                    ev = make_event(sofp_pkg::EvAbort, 8'd0, 1'b1);
                    return 1'b1;
                end
                ph = PhCmd0;
                return 1'b0;
            end
            PhCmd0:
            begin
                xor_acc ^= b;
                ph = PhCmd1;
                ev = make_event(sofp_pkg::EvCmd0, b, 1'b0);
                return 1'b1;
            end
            PhCmd1:
            begin
                xor_acc     ^= b;
                payload_left = len_decl;
                ph           = (len_decl != 16'd0) ? PhPayload : PhCheck;
                ev           = make_event(sofp_pkg::EvCmd1, b, 1'b0);
                return 1'b1;
            end
            PhPayload:
            begin
                xor_acc     ^= b;
                payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                    ph = PhCheck;
                ev = make_event(sofp_pkg::EvPayload, b, 1'b0);
                return 1'b1;
            end
            PhCheck:
            begin
                // unchecked frames take any trailing byte
                if (is_checked && b != xor_acc)
                begin
                    ph = PhDrop;
                    ev = make_event(sofp_pkg::EvBad, 8'd0, 1'b1);
                end
                else
                begin
                    ph = PhHunt;
                    ev = make_event(sofp_pkg::EvGood, 8'd0, 1'b1);
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (mismatch_count < 10)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     results_checked, what, want, got);
        mismatch_count++;
    endtask

    // driver: new item only once the previous one was taken
    always @(negedge clk)
    begin
        if (!item_valid || item_done)
        begin
            if (rst_n && !sender_hold && pending_items.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: check results first, then predict from the item taken at this edge
    always @(posedge clk)
    begin
        item_done = 1'b0;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_events.size() == 0)
            begin
                flag_mismatch("result with nothing expected, event_code", 16'd0,
                              16'(result.event_code));
            end
            else
            begin
                wanted_event = expected_events.pop_front();
                if (wanted_event.event_code <= sofp_pkg::EvAbort)
                    event_tally[wanted_event.event_code]++;
                if (result.event_code !== wanted_event.event_code)
                    flag_mismatch("event_code", 16'(wanted_event.event_code),
                                  16'(result.event_code));
                if (result.out_byte !== wanted_event.out_byte)
                    flag_mismatch("out_byte", 16'(wanted_event.out_byte),
                                  16'(result.out_byte));
                if (result.frame_length !== wanted_event.frame_length)
                    flag_mismatch("frame_length", wanted_event.frame_length,
                                  result.frame_length);
                if (result.frame_end !== wanted_event.frame_end)
                    flag_mismatch("frame_end", 16'(wanted_event.frame_end),
                                  16'(result.frame_end));
            end
            results_checked++;
        end
        if (rst_n && item_valid && !item_stall)
        begin
            item_done = 1'b1;
            items_accepted++;
            if (parse_step(item, predicted_event))
                expected_events.push_back(predicted_event);
        end
    end

    task automatic push_item(input logic kind, input logic [7:0] b);
        sofp_pkg::item_t it;
        it.kind    = kind;
        it.rx_byte = b;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(sofp_pkg::KindByte, b);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_item(sofp_pkg::KindTick, 8'($urandom));
    endtask

    task automatic write_cfg(input logic [sofp_pkg::CfgIndexWidth-1:0] idx,
                             input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == sofp_pkg::CfgIdleTicks)
            idle_ticks_cfg = val[7:0];
        else if (idx == sofp_pkg::CfgMaxDataLength)
            max_len_cfg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until the stream is consumed and the pipeline has emptied
    task automatic drain_parser();
        while (pending_items.size() != 0 || item_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned pick_length();
        int unsigned hi;
        int          r;
        hi = (max_len_cfg < 16'd40) ? max_len_cfg : 40;
        r  = $urandom_range(99);
        if (r < 80)
            return $urandom_range(0, (hi < 6) ? hi : 6);
        else if (r < 90)
            return $urandom_range(0, hi);
        else if (r < 94 || max_len_cfg == 16'hFFFF)
            return hi;
        else
            return $urandom_range(int'(max_len_cfg) + 1, 65535);
    endfunction

    // cut < 0 sends the whole frame, otherwise only its first cut bytes
    task automatic queue_frame(input bit checked, input int unsigned plen, input bit corrupt,
                               input int cut);
        logic [7:0]  body [$];
        logic [7:0]  acc;
        logic [15:0] len16;
        bit          left_open;
        int          n;
        int          n_end;
        len16     = plen[15:0];
        acc       = len16[15:8] ^ len16[7:0];
        left_open = 1'b0;
        body.push_back(checked ? sofp_pkg::SofChecked : sofp_pkg::SofUnchecked);
        body.push_back(len16[15:8]);
        body.push_back(len16[7:0]);
        if (plen > max_len_cfg)
        begin
            // oversize: whatever follows is dropped until a timeout
            left_open = 1'b1;
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        end
        else
        begin
            repeat (plen + 2)
            begin
                body.push_back(8'($urandom));
                acc ^= body[body.size() - 1];
            end
            if (corrupt)
            begin
                body.push_back(acc ^ 8'($urandom_range(1, 255)));
                left_open = checked;
            end
            else
            begin
                body.push_back(checked ? acc : 8'($urandom));
            end
        end
        n_end = body.size();
        if (cut >= 0 && cut < body.size())
        begin
            n_end     = cut;
            left_open = 1'b1;
        end
        for (n = 0; n < n_end; n++)
        begin
            if (n != 0 && $urandom_range(99) < 6)
                push_ticks(1);
            push_byte(body[n]);
        end
        if (left_open)
            push_ticks(idle_ticks_cfg + 1);
    endtask

    // mostly well-formed frames, some truncated ones and some line noise
    task automatic queue_traffic(input int budget);
        int          first;
        int          r;
        int unsigned plen;
        first = items_queued;
        while (items_queued - first < budget)
        begin
            r    = $urandom_range(99);
            plen = pick_length();
            if (r < 70)
            begin
                queue_frame($urandom_range(1), plen, $urandom_range(99) < 15, -1);
            end
            else if (r < 85)
            begin
                queue_frame($urandom_range(1), plen, 1'b0, $urandom_range(1, plen + 4));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(1))
                        push_ticks(1);
                    else
                        push_byte(8'($urandom));
                end
                if ($urandom_range(1))
                    push_ticks(idle_ticks_cfg + 1);
            end
        end
    endtask

    initial
    begin
        int p;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick while hunting with the idle counter at zero: nothing happens
        push_ticks(1);
        // checked frame, one payload byte, correct xor
        push_byte(8'hFE); push_byte(8'h00); push_byte(8'h01);
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80); push_byte(8'h7E);
        // length 1019 is one above the reset limit, then timeout while dropping
        push_byte(8'hFE); push_byte(8'h03); push_byte(8'hFB);
        push_ticks(4);
        // bad checksum, then timeout while dropping
        push_byte(8'hFE); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h01); push_byte(8'h02); push_byte(8'h00);
        push_ticks(4);
        drain_parser();

        // zero idle ticks: first tick aborts, frame_length holds only the high byte
        write_cfg(sofp_pkg::CfgIdleTicks, 16'd0);
        @(posedge clk);
        push_byte(8'hFF); push_byte(8'h80);
        push_ticks(1);
        // unchecked frame with empty payload and an arbitrary check byte
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h33);
        drain_parser();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'(sofp_pkg::IdleTicksReset));
                    write_cfg(sofp_pkg::CfgMaxDataLength, sofp_pkg::MaxDataLengthReset);
                end
                1:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'd0);
                    write_cfg(sofp_pkg::CfgMaxDataLength, 16'd0);
                end
                2:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'd255);
                    write_cfg(sofp_pkg::CfgMaxDataLength, 16'hFFFF);
                end
                3:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'($urandom_range(1, 8)));
                    write_cfg(sofp_pkg::CfgMaxDataLength, 16'($urandom_range(0, 40)));
                end
                4:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'd1);
                    write_cfg(sofp_pkg::CfgMaxDataLength, 16'hFFFE);
                end
                default:
                begin
                    write_cfg(sofp_pkg::CfgIdleTicks, 16'($urandom_range(0, 4)));
                    write_cfg(sofp_pkg::CfgMaxDataLength, 16'($urandom_range(41, 2000)));
                end
            endcase
            @(posedge clk);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                end
                default:
                begin
                    send_idle_pct = 25;
                    stall_pct     = 25;
                end
            endcase
            if (p == 5)
            begin
                send_idle_pct = 25;
                stall_pct     = 25;
            end
            queue_traffic(325);
            if (p == 2)
            begin
                // hold the sender until every pending result is out
                while (pending_items.size() > 150)
                    @(posedge clk);
                sender_hold = 1'b1;
                while (expected_events.size() != 0)
                    @(posedge clk);
                sender_hold = 1'b0;
            end
            drain_parser();
        end

        $display("covered %0d items: directed corner frames plus six random phases",
                 items_accepted);
        $display("results %0d: cmd0 %0d, cmd1 %0d, payload %0d, good %0d, bad %0d, abort %0d",
                 results_checked, event_tally[sofp_pkg::EvCmd0],
                 event_tally[sofp_pkg::EvCmd1], event_tally[sofp_pkg::EvPayload],
                 event_tally[sofp_pkg::EvGood], event_tally[sofp_pkg::EvBad],
                 event_tally[sofp_pkg::EvAbort]);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results still expected", expected_events.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
